// File: src/snm_pkg.sv
`timescale 1ns / 1ps

package snm_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // coordinate width, covers the largest supported image size
  localparam int DIM_W = 13;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 8;
  localparam int SIZE_W   = 9;
  localparam int CHAN_W   = 16;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HEIGHT_GAIN  = 2'd2;

  // item kinds
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // neighbor offset codes
  typedef enum logic [1:0] {
    OFS_MINUS = 2'b00,
    OFS_ZERO  = 2'b01,
    OFS_PLUS  = 2'b10
  } ofs_t;

  // neighbor order: (-1,-1) (0,-1) (+1,-1) (-1,0) (+1,0) (-1,+1) (0,+1) (+1,+1)
  function automatic ofs_t nb_dcol(input logic [2:0] k);
    ofs_t o;
    case (k)
      3'd0, 3'd3, 3'd5: o = OFS_MINUS;
      3'd1, 3'd6:       o = OFS_ZERO;
      default:          o = OFS_PLUS;
    endcase
    return o;
  endfunction

  function automatic ofs_t nb_drow(input logic [2:0] k);
    ofs_t o;
    case (k)
      3'd0, 3'd1, 3'd2: o = OFS_MINUS;
      3'd3, 3'd4:       o = OFS_ZERO;
      default:          o = OFS_PLUS;
    endcase
    return o;
  endfunction

  function automatic logic signed [2:0] sobel_kx(input logic [2:0] k);
    logic signed [2:0] c;
    case (k)
      3'd0, 3'd5: c = -3'sd1;
      3'd2, 3'd7: c = 3'sd1;
      3'd3:       c = -3'sd2;
      3'd4:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] sobel_ky(input logic [2:0] k);
    logic signed [2:0] c;
    case (k)
      3'd0, 3'd2: c = -3'sd1;
      3'd5, 3'd7: c = 3'sd1;
      3'd1:       c = -3'sd2;
      3'd6:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

endpackage

// File: src/sobel_normal_map_pixel_core.sv
`timescale 1ns / 1ps
// a compute word goes from accept to out_tvalid through these steps, and also waits out any output stall
// (neighbor reads, 7 multiply steps, two 29-step square roots, three 18-step divides)
// a new compute word is taken only once the last one is done; write words are taken every cycle while idle
// the shared compare-subtract unit and the single multiplier set the rate
// reset (rst_n low, synchronous) clears control and restores the configuration registers
// the height store has no reset; its entries hold garbage until written
module sobel_normal_map_pixel_core #(
  parameter int MAX_WIDTH  = snm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = snm_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // col[7:0], row[15:8], height_sample[31:16]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red[15:0], green[31:16], blue[47:32]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);

  localparam int DW   = snm_pkg::DIM_W;
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int RW   = 20;   // raw kernel sum
  localparam int GW   = 28;   // scaled gradient
  localparam int WW   = 29;   // doubled normal component
  localparam int MW   = 29;   // multiplier operand
  localparam int SW   = 2 * MW;
  localparam int MAGW = 27;
  localparam int LENW = 29;
  localparam int SQRT_LAST = SW / 2 - 1;   // sqrt iterations minus one
  localparam int DIV_LAST  = 16;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_DINIT = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [snm_pkg::SIZE_W-1:0] image_width_r, image_height_r;
  logic [snm_pkg::GAIN_W-1:0] height_gain_r;

  logic [snm_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [snm_pkg::SAMPLE_W-1:0] rd_r;
  logic [AW-1:0] raddr, waddr;
  logic          mem_we;

  logic [DW-1:0] c0_r, r0_r, lastc_r, lastr_r, c0_nxt, r0_nxt, lastc_nxt, lastr_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic signed [RW-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [GW-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [1:0]    mstep_r, mstep_nxt, ch_r, ch_nxt;
  logic          pass_r, pass_nxt;
  logic [SW-1:0] acc_r, acc_nxt, rem_r, rem_nxt, sh_r, sh_nxt, res_r, res_nxt;
  logic [4:0]    it_r, it_nxt;
  logic [MAGW-1:0] mag_r, mag_nxt;
  logic [LENW-1:0] len_r, len_nxt;
  logic [snm_pkg::CHAN_W-1:0] q0_r, q1_r, q2_r, q0_nxt, q1_nxt, q2_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;
  logic signed [WW-1:0]   wx, wy, wz, wsel;
  logic [SW-1:0]  trial, diff, wu;
  logic           ge;
  logic [DW-1:0]  weff, heff, in_col, in_row, nb_col, nb_row;
  logic [2*DW-1:0] raddr_full, waddr_full;
  logic [2:0]     k_issue, k_data;
  logic signed [2:0] kx_c, ky_c;
  logic signed [RW-1:0] samp, kxs, kys;
  logic           in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_acc     = in_tvalid && in_tready;

  // effective image size
  always_comb begin
    weff = DW'(image_width_r);
    if (image_width_r == '0) weff = DW'(1);
    else if (DW'(image_width_r) > DW'(MAX_WIDTH)) weff = DW'(MAX_WIDTH);
    heff = DW'(image_height_r);
    if (image_height_r == '0) heff = DW'(1);
    else if (DW'(image_height_r) > DW'(MAX_HEIGHT)) heff = DW'(MAX_HEIGHT);
  end

  assign in_col = DW'(in_tdata[7:0]);
  assign in_row = DW'(in_tdata[15:8]);

  // store write
  assign mem_we     = in_acc && (in_tuser == snm_pkg::OP_WRITE) &&
                      (in_col < DW'(MAX_WIDTH)) && (in_row < DW'(MAX_HEIGHT));
  assign waddr_full = in_row * (2*DW)'(MAX_WIDTH) + (2*DW)'(in_col);
  assign waddr      = waddr_full[AW-1:0];

  // neighbor address, clamp to edge
  assign k_issue = cnt_r[2:0];
  assign k_data  = 3'(cnt_r - 4'd1);
  always_comb begin
    case (snm_pkg::nb_dcol(k_issue))
      snm_pkg::OFS_MINUS: nb_col = (c0_r == '0) ? c0_r : c0_r - DW'(1);
      snm_pkg::OFS_PLUS:  nb_col = (c0_r == lastc_r) ? c0_r : c0_r + DW'(1);
      default:            nb_col = c0_r;
    endcase
    case (snm_pkg::nb_drow(k_issue))
      snm_pkg::OFS_MINUS: nb_row = (r0_r == '0) ? r0_r : r0_r - DW'(1);
      snm_pkg::OFS_PLUS:  nb_row = (r0_r == lastr_r) ? r0_r : r0_r + DW'(1);
      default:            nb_row = r0_r;
    endcase
  end
  assign raddr_full = nb_row * (2*DW)'(MAX_WIDTH) + (2*DW)'(nb_col);
  assign raddr      = raddr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_tdata[31:16];
    end
    rd_r <= mem[raddr];
  end

  // kernel accumulation on raw samples, gain applied afterwards
  assign kx_c = snm_pkg::sobel_kx(k_data);
  assign ky_c = snm_pkg::sobel_ky(k_data);
  assign samp = $signed({{(RW-snm_pkg::SAMPLE_W){1'b0}}, rd_r});
  assign kxs  = {{(RW-3){kx_c[2]}}, kx_c};
  assign kys  = {{(RW-3){ky_c[2]}}, ky_c};

  // doubled normal vector
  assign wx = WW'(65536) - {{(WW-GW){gx_r[GW-1]}}, gx_r};
  assign wy = WW'(65536) - {{(WW-GW){gy_r[GW-1]}}, gy_r};
  assign wz = WW'(65536) + $signed({{(WW-MAGW){1'b0}}, mag_r});

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (!pass_r) begin
      case (mstep_r)
        2'd0: begin
          mul_a = {{(MW-RW){rx_r[RW-1]}}, rx_r};
          mul_b = $signed({{(MW-snm_pkg::GAIN_W){1'b0}}, height_gain_r});
        end
        2'd1: begin
          mul_a = {{(MW-RW){ry_r[RW-1]}}, ry_r};
          mul_b = $signed({{(MW-snm_pkg::GAIN_W){1'b0}}, height_gain_r});
        end
        2'd2: begin
          mul_a = {{(MW-GW){gx_r[GW-1]}}, gx_r};
          mul_b = mul_a;
        end
        default: begin
          mul_a = {{(MW-GW){gy_r[GW-1]}}, gy_r};
          mul_b = mul_a;
        end
      endcase
    end else begin
      case (mstep_r)
        2'd0:    mul_a = wx;
        2'd1:    mul_a = wy;
        default: mul_a = wz;
      endcase
      mul_b = mul_a;
    end
  end
  assign prod = mul_a * mul_b;

  // shared compare-subtract unit: square root step or restoring divide step
  assign trial = (state_r == S_ROOT) ? res_r + sh_r : sh_r;
  assign ge    = (rem_r >= trial);
  assign diff  = rem_r - trial;

  always_comb begin
    case (ch_r)
      2'd0:    wsel = wx;
      2'd1:    wsel = wy;
      default: wsel = wz;
    endcase
    wu   = SW'(wsel[WW-2:0]);
  end

  always_comb begin
    state_nxt     = state_r;
    c0_nxt        = c0_r;
    r0_nxt        = r0_r;
    lastc_nxt     = lastc_r;
    lastr_nxt     = lastr_r;
    cnt_nxt       = cnt_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    mstep_nxt     = mstep_r;
    ch_nxt        = ch_r;
    pass_nxt      = pass_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    res_nxt       = res_r;
    it_nxt        = it_r;
    mag_nxt       = mag_r;
    len_nxt       = len_r;
    q0_nxt        = q0_r;
    q1_nxt        = q1_r;
    q2_nxt        = q2_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == snm_pkg::OP_COMPUTE)) begin
          c0_nxt    = (in_col >= weff) ? weff - DW'(1) : in_col;
          r0_nxt    = (in_row >= heff) ? heff - DW'(1) : in_row;
          lastc_nxt = weff - DW'(1);
          lastr_nxt = heff - DW'(1);
          cnt_nxt   = '0;
          rx_nxt    = '0;
          ry_nxt    = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r != '0) begin
          rx_nxt = rx_r + samp * kxs;
          ry_nxt = ry_r + samp * kys;
        end
        if (cnt_r == 4'd8) begin
          mstep_nxt = '0;
          pass_nxt  = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mstep_nxt = mstep_r + 2'd1;
        if (!pass_r) begin
          case (mstep_r)
            2'd0:    gx_nxt = prod[GW-1:0];
            2'd1:    gy_nxt = prod[GW-1:0];
            2'd2:    acc_nxt = $unsigned(prod);
            default: acc_nxt = acc_r + $unsigned(prod);
          endcase
        end else begin
          acc_nxt = (mstep_r == 2'd0) ? $unsigned(prod) : acc_r + $unsigned(prod);
        end
        if ((!pass_r && mstep_r == 2'd3) || (pass_r && mstep_r == 2'd2)) begin
          rem_nxt   = acc_r + $unsigned(prod);
          res_nxt   = '0;
          sh_nxt    = SW'(1) << (2 * SQRT_LAST);
          it_nxt    = 5'(SQRT_LAST);
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (ge) begin
          rem_nxt = diff;
          res_nxt = (res_r >> 1) + sh_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        sh_nxt = sh_r >> 2;
        it_nxt = it_r - 5'd1;
        if (it_r == '0) begin
          if (!pass_r) begin
            mag_nxt   = res_nxt[MAGW-1:0];
            pass_nxt  = 1'b1;
            mstep_nxt = '0;
            state_nxt = S_MUL;
          end else begin
            len_nxt   = res_nxt[LENW-1:0];
            ch_nxt    = '0;
            state_nxt = S_DINIT;
          end
        end
      end
      S_DINIT: begin
        // nonpositive components leave a zero dividend, so the quotient is zero
        if (!wsel[WW-1] && wsel != '0) begin
          rem_nxt = (wu << 16) - wu + (SW'(len_r) >> 1);
        end else begin
          rem_nxt = '0;
        end
        sh_nxt    = SW'(len_r) << DIV_LAST;
        res_nxt   = '0;
        it_nxt    = 5'(DIV_LAST);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (ge) begin
          rem_nxt = diff;
        end
        res_nxt = {res_r[SW-2:0], ge};
        sh_nxt  = sh_r >> 1;
        it_nxt  = it_r - 5'd1;
        if (it_r == '0) begin
          state_nxt = S_DINIT;
          ch_nxt    = ch_r + 2'd1;
          case (ch_r)
            2'd0:    q0_nxt = (res_nxt[16]) ? 16'hFFFF : res_nxt[15:0];
            2'd1:    q1_nxt = (res_nxt[16]) ? 16'hFFFF : res_nxt[15:0];
            default: begin
              q2_nxt    = (res_nxt[16]) ? 16'hFFFF : res_nxt[15:0];
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {q2_r, q1_r, q0_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      image_width_r  <= 9'd256;
      image_height_r <= 9'd256;
      height_gain_r  <= 8'd25;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          snm_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
          snm_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
          snm_pkg::REG_HEIGHT_GAIN:  height_gain_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    c0_r       <= c0_nxt;
    r0_r       <= r0_nxt;
    lastc_r    <= lastc_nxt;
    lastr_r    <= lastr_nxt;
    cnt_r      <= cnt_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    mstep_r    <= mstep_nxt;
    ch_r       <= ch_nxt;
    pass_r     <= pass_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    sh_r       <= sh_nxt;
    res_r      <= res_nxt;
    it_r       <= it_nxt;
    mag_r      <= mag_nxt;
    len_r      <= len_nxt;
    q0_r       <= q0_nxt;
    q1_r       <= q1_nxt;
    q2_r       <= q2_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == snm_pkg::OP_COMPUTE) |=> !in_tready)
    else $error("input still ready after a compute word");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == snm_pkg::OP_WRITE) && !out_tvalid
    |=> !out_tvalid)
    else $error("write word produced a result");
`endif

endmodule

// File: tb/sv/tb_sobel_normal_map_pixel_core.sv
`timescale 1ns / 1ps

module tb_sobel_normal_map_pixel_core;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 8000;
  localparam int LONG_HOLD = 600;
  localparam int SPAN = 16;

  typedef struct {
    logic        op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] sample;
  } px_word_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [8:0]  cfg_wdata;

  sobel_normal_map_pixel_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // model state
  logic [15:0] sample_mdl [65536];
  bit          sample_known [65536];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [7:0]  gain_reg;

  px_word_t pending_q[$];
  rgb_t     normal_q[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  in_took = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  out_hold = 0;
  bit  hold_req = 0;
  bit  calm = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic int clamp_to(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_channel(longint w, longint unsigned len);
    longint unsigned q;
    if (w <= 0) return 16'd0;
    q = (longint'(w) * 65535 + len / 2) / len;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic rgb_t predict_normal(logic [7:0] c_in, logic [7:0] r_in);
    int     w, h, c, r, k;
    longint s [3][3];
    longint gx, gy, mag, wx, wy, wz;
    longint unsigned len;
    rgb_t   o;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    c = clamp_to(int'(c_in), w);
    r = clamp_to(int'(r_in), h);
    for (int dr = 0; dr < 3; dr++)
      for (int dc = 0; dc < 3; dc++) begin
        k = clamp_to(r + dr - 1, h) * 256 + clamp_to(c + dc - 1, w);
        s[dr][dc] = longint'(sample_mdl[k]) * longint'(gain_reg);
      end
    gx = -s[0][0] + s[0][2] - 2 * s[1][0] + 2 * s[1][2] - s[2][0] + s[2][2];
    gy = -s[0][0] - 2 * s[0][1] - s[0][2] + s[2][0] + 2 * s[2][1] + s[2][2];
    mag = longint'(root_floor(gx * gx + gy * gy));
    wx = 65536 - gx;
    wy = 65536 - gy;
    wz = 65536 + mag;
    len = root_floor(wx * wx + wy * wy + wz * wz);
    o.red = to_channel(wx, len);
    o.green = to_channel(wy, len);
    o.blue = to_channel(wz, len);
    return o;
  endfunction

  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      in_took = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_q[0].op;
        in_tdata <= {pending_q[0].sample, pending_q[0].row, pending_q[0].col};
        in_gap = draw_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      out_hold = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = draw_gap();
    end
  end

  // monitor: predict on accepted words, check accepted results
  always @(posedge clk) begin
    px_word_t wd;
    rgb_t     exp_px;
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        idle_cycles = 0;
        in_took = 1;
        wd = pending_q.pop_front();
        if (wd.op == snm_pkg::OP_WRITE)
          sample_mdl[{wd.row, wd.col}] = wd.sample;
        else
          normal_q.push_back(predict_normal(wd.col, wd.row));
      end
      if (out_tvalid && out_tready) begin
        idle_cycles = 0;
        if (normal_q.size() == 0) begin
          report($sformatf("unexpected word %h", out_tdata));
        end else begin
          exp_px = normal_q.pop_front();
          if (out_tdata[15:0] !== exp_px.red)
            report($sformatf("red %h, want %h", out_tdata[15:0], exp_px.red));
          if (out_tdata[31:16] !== exp_px.green)
            report($sformatf("green %h, want %h", out_tdata[31:16], exp_px.green));
          if (out_tdata[47:32] !== exp_px.blue)
            report($sformatf("blue %h, want %h", out_tdata[47:32], exp_px.blue));
        end
      end
      if (cfg_we) idle_cycles = 0;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_write(int c, int r, logic [15:0] v);
    px_word_t wd;
    wd.op = snm_pkg::OP_WRITE;
    wd.col = c[7:0];
    wd.row = r[7:0];
    wd.sample = v;
    sample_known[{wd.row, wd.col}] = 1;
    pending_q.push_back(wd);
  endtask

  // fills in any neighbor never written, so no undefined entry is read
  task automatic push_compute(int c_in, int r_in);
    int w, h, c, r;
    px_word_t wd;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    c = clamp_to(c_in, w);
    r = clamp_to(r_in, h);
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (!sample_known[clamp_to(r + dr, h) * 256 + clamp_to(c + dc, w)])
          push_write(clamp_to(c + dc, w), clamp_to(r + dr, h),
                     16'($urandom_range(0, 65535)));
    wd.op = snm_pkg::OP_COMPUTE;
    wd.col = c_in[7:0];
    wd.row = r_in[7:0];
    wd.sample = 16'($urandom_range(0, 65535));
    pending_q.push_back(wd);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_tvalid || normal_q.size() > 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [8:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      snm_pkg::REG_IMAGE_WIDTH:  width_reg = v;
      snm_pkg::REG_IMAGE_HEIGHT: height_reg = v;
      snm_pkg::REG_HEIGHT_GAIN:  gain_reg = v[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // most traffic stays in a small corner patch so few filler writes are needed
  task automatic random_phase(int n, int pressure);
    int w, h, ws, hs;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    ws = (w < SPAN) ? w : SPAN;
    hs = (h < SPAN) ? h : SPAN;
    for (int i = 0; i < n; i++) begin
      if (pressure == 1 && i == n / 2) hold_req = 1;
      if (pressure == 2 && i == n / 2) wait_drained();
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 9) == 0)
          push_write($urandom_range(0, 255), $urandom_range(0, 255),
                     16'($urandom_range(0, 65535)));
        else
          push_write($urandom_range(0, ws - 1), $urandom_range(0, hs - 1),
                     16'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 99) < 5) begin
        push_compute($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        push_compute($urandom_range(0, ws - 1), $urandom_range(0, hs - 1));
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = snm_pkg::OP_WRITE;
    out_tready = 0;
    cfg_we = 0;
    cfg_addr = snm_pkg::REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    gain_reg = 8'd25;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: corners, flat and steep patches, samples at both extremes
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        push_write(c, r, (c == 2) ? 16'hFFFF : 16'h0000);
    push_compute(1, 1);
    push_compute(0, 0);
    push_write(255, 255, 16'hFFFF);
    push_write(254, 255, 16'h0000);
    push_write(255, 254, 16'h8000);
    push_compute(255, 255);
    push_compute(255, 0);
    push_compute(0, 255);
    push_compute(128, 128);
    calm = 1;
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd255);
    push_compute(1, 1);
    push_compute(255, 255);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd0);
    push_compute(1, 1);
    set_reg(REG_UNUSED, 9'h1FF);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd2);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd2);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd200);
    // the first lies outside the image on both axes
    push_compute(200, 255);
    push_compute(1, 0);
    calm = 0;

    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd256);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd256);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd25);
    random_phase(300, 1);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd0);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd0);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd255);
    random_phase(150, 0);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd1);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd1);
    random_phase(100, 0);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd3);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd5);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd100);
    random_phase(250, 2);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd511);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd300);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd0);
    random_phase(150, 0);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd17);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd9);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'($urandom_range(1, 254)));
    calm = 1;
    random_phase(100, 0);
    calm = 0;
    random_phase(150, 1);
    set_reg(snm_pkg::REG_IMAGE_WIDTH, 9'd256);
    set_reg(snm_pkg::REG_IMAGE_HEIGHT, 9'd256);
    set_reg(snm_pkg::REG_HEIGHT_GAIN, 9'd255);
    random_phase(200, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
